FILE: design/assert_macros.svh
// Assertion macros for the interval table design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITOQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITOQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/itoq_pkg.sv
// Package: sizes, codes and state type of the interval table block.
package itoq_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TIME_WIDTH  = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ID_W        = 10;
	localparam int COUNT_W     = 11;
	localparam int EXT_W       = 33;
	localparam int SUM_W       = 42;
	localparam int ENTRY_W     = 2 * TIME_WIDTH;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_STAB   = 2'd2,
		MODE_RANGE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_SPAN = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

endpackage

FILE: design/itoq_if.sv
// Channel interfaces: request beats in, result beats out.
interface itoq_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        mode;
	logic [itoq_pkg::TIME_WIDTH-1:0]   low_time;
	logic [itoq_pkg::TIME_WIDTH-1:0]   high_time;

	modport source (output valid, mode, low_time, high_time, input ready);
	modport sink   (input valid, mode, low_time, high_time, output ready);
endinterface

interface itoq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [itoq_pkg::ID_W-1:0]         id_xor;
	logic [itoq_pkg::COUNT_W-1:0]      record_count;
	logic [itoq_pkg::TIME_WIDTH-1:0]   global_start;
	logic [itoq_pkg::TIME_WIDTH-1:0]   global_end;
	logic [itoq_pkg::EXT_W-1:0]        longest_extent;
	logic [itoq_pkg::SUM_W-1:0]        extent_total;

	modport source (output valid, status, id_xor, record_count, global_start, global_end,
		longest_extent, extent_total, input ready);
	modport sink   (input valid, status, id_xor, record_count, global_start, global_end,
		longest_extent, extent_total, output ready);
endinterface

FILE: design/itoq_ram.sv
// Generic simple dual-port RAM with registered read.
module itoq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/interval_table_overlap_query.sv
// Interval table with append, clear and brute-force overlap queries.
//
// Usage:
//   req carries one beat per command: mode (clear, append, stabbing query,
//   range query), low_time and high_time. rsp returns exactly one beat per
//   command with status, the XOR of matching ids and the running statistics.
//   Both channels move a beat when valid and ready are high at a clock edge.
// Sequencing:
//   Clear and append finish in the accept cycle and go to ST_RESULT, which
//   loads the output register. A query reads one stored entry per cycle in
//   ST_SCAN through the single RAM read port and one pair of comparators,
//   then passes ST_DRAIN and ST_RESULT (on an empty table, only ST_RESULT).
//   One command is worked on at a time; req.ready is high only in ST_IDLE.
// Reset:
//   arst_n clears the count and the statistics (minimum start all ones). The
//   RAM is not cleared; entries at or above the count are never read.
// Stalls:
//   A result beat holds in the output register until rsp.ready. The next
//   command may be accepted meanwhile; its result waits behind the held one.
module interval_table_overlap_query (
	input  logic             clk,
	input  logic             arst_n,
	itoq_req_if.sink         req,
	itoq_rsp_if.source       rsp
);

`include "assert_macros.svh"

	localparam int TW = itoq_pkg::TIME_WIDTH;
	localparam int IW = itoq_pkg::IDX_W;
	localparam int CW = itoq_pkg::COUNT_W;

	itoq_pkg::state_t state_q, state_d;

	// table statistics
	logic [CW-1:0]                 count_q;
	logic [TW-1:0]                 min_start_q;
	logic [TW-1:0]                 max_end_q;
	logic [itoq_pkg::EXT_W-1:0]    max_ext_q;
	logic [itoq_pkg::SUM_W-1:0]    ext_sum_q;

	// per-command working registers
	itoq_pkg::status_t             status_q;
	logic [itoq_pkg::ID_W-1:0]     acc_q;
	logic [TW-1:0]                 qs_q;
	logic [TW-1:0]                 qe_q;
	logic [IW-1:0]                 rd_idx_q;

	// read pipeline
	logic                          rd_vld_s1;
	logic [IW-1:0]                 rd_id_s1;
	logic [itoq_pkg::ENTRY_W-1:0]  rd_data;
	logic [TW-1:0]                 ent_start;
	logic [TW-1:0]                 ent_end;

	// output register
	logic                          out_valid_q;
	itoq_pkg::status_t             out_status_q;
	logic [itoq_pkg::ID_W-1:0]     out_id_q;
	logic [CW-1:0]                 out_count_q;
	logic [TW-1:0]                 out_start_q;
	logic [TW-1:0]                 out_end_q;
	logic [itoq_pkg::EXT_W-1:0]    out_ext_q;
	logic [itoq_pkg::SUM_W-1:0]    out_sum_q;

	// control
	logic                          accept;
	logic                          rd_en;
	logic                          out_load;
	logic                          scan_last;
	logic                          ram_wr;
	itoq_pkg::mode_t               mode;
	logic                          bad_span;
	logic                          full;
	logic [TW-1:0]                 span;
	logic [itoq_pkg::EXT_W-1:0]    ext;
	logic                          hit;

	assign mode      = itoq_pkg::mode_t'(req.mode);
	assign accept    = req.valid && req.ready;
	assign bad_span  = req.low_time > req.high_time;
	assign full      = count_q >= CW'(itoq_pkg::TABLE_DEPTH);
	assign span      = req.high_time - req.low_time;
	assign ext       = {1'b0, span} + itoq_pkg::EXT_W'(1);
	assign ram_wr    = accept && (mode == itoq_pkg::MODE_APPEND) && !bad_span && !full;
	assign scan_last = ({1'b0, rd_idx_q} + CW'(1)) == count_q;

	assign ent_start = rd_data[itoq_pkg::ENTRY_W-1:TW];
	assign ent_end   = rd_data[TW-1:0];
	// the one compare unit: entry overlaps the closed query range
	assign hit       = (ent_start <= qe_q) && (qs_q <= ent_end);

	itoq_ram #(
		.WIDTH(itoq_pkg::ENTRY_W),
		.DEPTH(itoq_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (count_q[IW-1:0]),
		.wr_data ({req.low_time, req.high_time}),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itoq_pkg::ST_IDLE: begin
				if (accept) begin
					if ((mode == itoq_pkg::MODE_STAB || mode == itoq_pkg::MODE_RANGE)
						&& count_q != '0) begin
						state_d = itoq_pkg::ST_SCAN;
					end else begin
						state_d = itoq_pkg::ST_RESULT;
					end
				end
			end
			itoq_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = itoq_pkg::ST_DRAIN;
				end
			end
			itoq_pkg::ST_DRAIN: begin
				state_d = itoq_pkg::ST_RESULT;
			end
			itoq_pkg::ST_RESULT: begin
				if (out_load) begin
					state_d = itoq_pkg::ST_IDLE;
				end
			end
			default: state_d = itoq_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			itoq_pkg::ST_IDLE:   req.ready = 1'b1;
			itoq_pkg::ST_SCAN:   rd_en     = 1'b1;
			itoq_pkg::ST_DRAIN:  ;
			itoq_pkg::ST_RESULT: out_load  = !out_valid_q || rsp.ready;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoq_pkg::ST_IDLE;
			count_q     <= '0;
			min_start_q <= '1;
			max_end_q   <= '0;
			max_ext_q   <= '0;
			ext_sum_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				unique case (mode)
					itoq_pkg::MODE_CLEAR: begin
						count_q     <= '0;
						min_start_q <= '1;
						max_end_q   <= '0;
						max_ext_q   <= '0;
						ext_sum_q   <= '0;
					end
					itoq_pkg::MODE_APPEND: begin
						if (ram_wr) begin
							count_q <= count_q + CW'(1);
							if (req.low_time < min_start_q) begin
								min_start_q <= req.low_time;
							end
							if (req.high_time > max_end_q) begin
								max_end_q <= req.high_time;
							end
							if (ext > max_ext_q) begin
								max_ext_q <= ext;
							end
							ext_sum_q <= ext_sum_q + itoq_pkg::SUM_W'(span);
						end
					end
					itoq_pkg::MODE_STAB,
					itoq_pkg::MODE_RANGE: ;
					default: ;
				endcase
			end
			// drop valid once taken, unless a fresh result replaces it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers: no reset needed
	always_ff @(posedge clk) begin
		rd_id_s1 <= rd_idx_q;
		if (accept) begin
			acc_q    <= '0;
			rd_idx_q <= '0;
			qs_q     <= req.low_time;
			qe_q     <= (mode == itoq_pkg::MODE_STAB) ? req.low_time : req.high_time;
			priority if (mode != itoq_pkg::MODE_APPEND) begin
				status_q <= itoq_pkg::STATUS_OK;
			end else if (bad_span) begin
				status_q <= itoq_pkg::STATUS_BAD_SPAN;
			end else if (full) begin
				status_q <= itoq_pkg::STATUS_FULL;
			end else begin
				status_q <= itoq_pkg::STATUS_OK;
			end
		end else begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			// fold the id of each matching entry into the accumulator
			if (rd_vld_s1 && hit) begin
				acc_q <= acc_q ^ rd_id_s1[itoq_pkg::ID_W-1:0];
			end
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_id_q     <= acc_q;
			out_count_q  <= count_q;
			out_start_q  <= min_start_q;
			out_end_q    <= max_end_q;
			out_ext_q    <= max_ext_q;
			out_sum_q    <= ext_sum_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.id_xor         = out_id_q;
	assign rsp.record_count   = out_count_q;
	assign rsp.global_start   = out_start_q;
	assign rsp.global_end     = out_end_q;
	assign rsp.longest_extent = out_ext_q;
	assign rsp.extent_total   = out_sum_q;

	`ITOQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(itoq_pkg::TABLE_DEPTH), "count beyond table depth")
	`ITOQ_ASSERT_NOW(a_scan_in_table, state_q == itoq_pkg::ST_SCAN, ({1'b0, rd_idx_q} < count_q), "scan past stored entries")
	`ITOQ_ASSERT_NOW(a_no_accept_scan, req.ready, !rd_vld_s1 && !rd_en, "command taken during a scan")
	`ITOQ_ASSERT_NEXT(a_clear_empties, accept && mode == itoq_pkg::MODE_CLEAR, count_q == '0, "clear left entries")
	`ITOQ_ASSERT_NEXT(a_bad_span_keeps, accept && mode == itoq_pkg::MODE_APPEND && bad_span, $stable(count_q), "rejected append stored")

endmodule

FILE: dv/itoq_result_checker.sv
// Result checker for the interval table: predicts each result beat and compares it.
`timescale 1ns / 100ps

module itoq_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	itoq_req_if        req,
	itoq_rsp_if        rsp,
	output int         mismatches,
	output int         outstanding
);
	import itoq_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic [ID_W-1:0]         id_xor;
		logic [COUNT_W-1:0]      record_count;
		logic [TIME_WIDTH-1:0]   global_start;
		logic [TIME_WIDTH-1:0]   global_end;
		logic [EXT_W-1:0]        longest_extent;
		logic [SUM_W-1:0]        extent_total;
	} table_result_t;

	logic [TIME_WIDTH-1:0] held_start [TABLE_DEPTH];
	logic [TIME_WIDTH-1:0] held_end   [TABLE_DEPTH];
	logic [COUNT_W-1:0]    held_count;
	logic [TIME_WIDTH-1:0] least_start;
	logic [TIME_WIDTH-1:0] greatest_end;
	logic [EXT_W-1:0]      widest_extent;
	logic [SUM_W-1:0]      span_sum;

	table_result_t awaited_results [$];

	// Apply one command to the shadow table and return the result it yields.
	function automatic table_result_t apply_command(mode_t op, logic [TIME_WIDTH-1:0] lo,
		logic [TIME_WIDTH-1:0] hi);
		table_result_t         res;
		logic [EXT_W-1:0]      ext;
		logic [TIME_WIDTH-1:0] q_end;
		logic [ID_W-1:0]       hits;
		res = '0;
		res.status = STATUS_OK;
		hits = '0;
		case (op)
			MODE_CLEAR: begin
				held_count    = '0;
				least_start   = '1;
				greatest_end  = '0;
				widest_extent = '0;
				span_sum      = '0;
			end
			MODE_APPEND: begin
				// a reversed span is refused before the table is checked for room
				if (lo > hi) begin
					res.status = STATUS_BAD_SPAN;
				end else if (held_count >= TABLE_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					held_start[held_count[IDX_W-1:0]] = lo;
					held_end[held_count[IDX_W-1:0]]   = hi;
					held_count = held_count + 1'b1;
					if (lo < least_start) least_start = lo;
					if (hi > greatest_end) greatest_end = hi;
					ext = {1'b0, hi - lo};
					ext = ext + 1'b1;
					if (ext > widest_extent) widest_extent = ext;
					span_sum = span_sum + {{(SUM_W-TIME_WIDTH){1'b0}}, hi - lo};
				end
			end
			default: begin
				q_end = (op == MODE_STAB) ? lo : hi;
				for (int i = 0; i < held_count; i++) begin
					if (held_start[i] <= q_end && lo <= held_end[i]) hits ^= ID_W'(i);
				end
				res.id_xor = hits;
			end
		endcase
		res.record_count   = held_count;
		res.global_start   = least_start;
		res.global_end     = greatest_end;
		res.longest_extent = widest_extent;
		res.extent_total   = span_sum;
		return res;
	endfunction

	task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			held_count    = '0;
			least_start   = '1;
			greatest_end  = '0;
			widest_extent = '0;
			span_sum      = '0;
			awaited_results.delete();
			mismatches    = 0;
			outstanding  <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no command waiting for it");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("id_xor", want.id_xor, rsp.id_xor);
					compare_field("record_count", want.record_count, rsp.record_count);
					compare_field("global_start", want.global_start, rsp.global_start);
					compare_field("global_end", want.global_end, rsp.global_end);
					compare_field("longest_extent", want.longest_extent, rsp.longest_extent);
					compare_field("extent_total", want.extent_total, rsp.extent_total);
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.push_back(apply_command(mode_t'(req.mode), req.low_time,
					req.high_time));
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: dv/tb.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module tb;
	import itoq_pkg::*;

	// Longest run of cycles without a beat on either channel before giving up.
	// A query on a full table scans every entry without a beat, and the long
	// hold-off adds more quiet time; leave a wide margin.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_OFF    = 300;
	localparam int PHASE_ITEMS = 145;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int sender_idle;     // percent of cycles the command side stays quiet
	int receiver_stall;  // percent of cycles the result side refuses a beat
	int hold_cycles;     // remaining cycles of a forced result hold-off
	int quiet_cycles;
	int mismatches;
	int outstanding;

	itoq_req_if req ();
	itoq_rsp_if rsp ();

	interval_table_overlap_query DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	itoq_result_checker results_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Time values: mostly a narrow window so that intervals overlap often,
	// some corner values, and the rest spread over the whole 32-bit range.
	function automatic logic [TIME_WIDTH-1:0] pick_time();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55) return TIME_WIDTH'($urandom_range(63));
		if (roll < 70) begin
			case ($urandom_range(3))
				0:       return '0;
				1:       return '1;
				2:       return {1'b0, {(TIME_WIDTH-1){1'b1}}};
				default: return {1'b1, {(TIME_WIDTH-1){1'b0}}};
			endcase
		end
		return TIME_WIDTH'($urandom());
	endfunction

	// Offer one command beat and hold it until the block takes it. Any idle
	// gap goes in front, so a back-to-back beat never drops valid in between.
	task automatic issue(mode_t op, logic [TIME_WIDTH-1:0] lo, logic [TIME_WIDTH-1:0] hi);
		while ($urandom_range(99) < sender_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.mode      <= op;
		req.low_time  <= lo;
		req.high_time <= hi;
		do @(posedge clk); while (!req.ready);
	endtask

	// Drop valid and wait for every predicted result to come back. The count
	// is sampled on the falling edge, clear of the updates at the rising one.
	task automatic pause_until_drained();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Result side: random stalls, or a forced hold-off counted down here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= receiver_stall);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [TIME_WIDTH-1:0] lo_v;
		logic [TIME_WIDTH-1:0] hi_v;
		int                    roll;

		req.valid      = 1'b0;
		req.mode       = MODE_CLEAR;
		req.low_time   = '0;
		req.high_time  = '0;
		rsp.ready      = 1'b0;
		sender_idle    = 0;
		receiver_stall = 0;
		hold_cycles    = 0;
		quiet_cycles   = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Queries on the empty table first: nothing can match.
		issue(MODE_STAB, '0, '1);
		issue(MODE_RANGE, '0, '1);
		// Widest possible interval, the top point alone and the bottom point alone.
		issue(MODE_APPEND, '0, '1);
		issue(MODE_APPEND, '1, '1);
		issue(MODE_APPEND, '0, '0);
		// Reversed spans are refused and leave the statistics alone.
		issue(MODE_APPEND, 32'd5, 32'd4);
		issue(MODE_APPEND, '1, '0);
		issue(MODE_APPEND, 32'd10, 32'd20);
		issue(MODE_STAB, '0, '1);
		issue(MODE_STAB, '1, '0);
		issue(MODE_STAB, 32'd15, 32'd0);
		issue(MODE_STAB, 32'd21, 32'd9);
		// A reversed range matches only intervals that reach over both of its ends.
		issue(MODE_RANGE, 32'd15, 32'd10);
		issue(MODE_RANGE, '0, '1);
		issue(MODE_RANGE, 32'd21, 32'd100);
		issue(MODE_RANGE, 32'd20, 32'd20);
		// Clear brings the statistics back to their reset values.
		issue(MODE_CLEAR, '1, '1);
		issue(MODE_STAB, '0, '0);
		issue(MODE_APPEND, 32'd7, 32'd7);
		issue(MODE_RANGE, 32'd7, 32'd7);
		issue(MODE_RANGE, 32'd8, '1);
		issue(MODE_CLEAR, '0, '0);
		pause_until_drained();

		// Fill the table to the brim. Most entries span nearly the whole time
		// range, pushing the extent sum into its top bits.
		for (int n = 0; n < TABLE_DEPTH; n++) begin
			if ($urandom_range(3) != 0) begin
				lo_v = TIME_WIDTH'($urandom_range(255));
				hi_v = '1 - TIME_WIDTH'($urandom_range(255));
			end else begin
				lo_v = pick_time();
				hi_v = pick_time();
				if (lo_v > hi_v) {lo_v, hi_v} = {hi_v, lo_v};
			end
			issue(MODE_APPEND, lo_v, hi_v);
		end
		// Full table: a good span is refused for room, a reversed one for order.
		issue(MODE_APPEND, 32'd1, 32'd2);
		issue(MODE_APPEND, '0, '1);
		issue(MODE_APPEND, 32'd9, 32'd3);
		// Scans over every entry.
		issue(MODE_STAB, 32'd100, 32'd0);
		issue(MODE_STAB, pick_time(), pick_time());
		issue(MODE_RANGE, '0, '1);
		issue(MODE_RANGE, 32'd300, 32'd301);
		issue(MODE_CLEAR, '0, '0);
		pause_until_drained();

		// Random part in four back-pressure settings: none, a slow sender,
		// a slow receiver, and both somewhat slow.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle    = 0;
					receiver_stall = 0;
					// Hold results off while commands keep coming, so the
					// block backs up and stalls its command side.
					hold_cycles    = HOLD_OFF;
				end
				1: begin
					sender_idle    = 80;
					receiver_stall = 0;
				end
				2: begin
					sender_idle    = 0;
					receiver_stall = 80;
				end
				default: begin
					sender_idle    = 29;
					receiver_stall = 29;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(99);
				lo_v = pick_time();
				hi_v = pick_time();
				if (roll < 4) begin
					issue(MODE_CLEAR, lo_v, hi_v);
				end else if (roll < 50) begin
					// Mostly well-ordered appends; now and then force a reversed one.
					if ($urandom_range(9) != 0) begin
						if (lo_v > hi_v) {lo_v, hi_v} = {hi_v, lo_v};
					end else if (lo_v < hi_v) begin
						{lo_v, hi_v} = {hi_v, lo_v};
					end
					issue(MODE_APPEND, lo_v, hi_v);
				end else if (roll < 75) begin
					issue(MODE_STAB, lo_v, hi_v);
				end else begin
					if ($urandom_range(7) != 0 && lo_v > hi_v) {lo_v, hi_v} = {hi_v, lo_v};
					issue(MODE_RANGE, lo_v, hi_v);
				end
			end
			pause_until_drained();
		end

		// Let any stray beat show itself before the verdict.
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/itoq_pkg.sv
design/itoq_if.sv
design/itoq_ram.sv
design/interval_table_overlap_query.sv
dv/itoq_result_checker.sv
dv/tb.sv
